FILE: hw/rtl/fthd_pkg.sv
// ----------------------------------------------------------------------------
// fthd_pkg
// Shared types, register indexes, reset values and codes for the fan
// thermostat drive unit.
// ----------------------------------------------------------------------------
package fthd_pkg;

  localparam int LEVEL_BITS_DEFAULT = 4;
  localparam int TEMP_W    = 12;
  localparam int HYST_W    = 10;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int WIDE_W    = TEMP_W + 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND  = 2'd2;

  localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RESET  = TEMP_W'(45 << 4);
  localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RESET = TEMP_W'(65 << 4);
  localparam logic [HYST_W-1:0]        HYST_BAND_RESET  = HYST_W'(3 << 4);

  localparam logic [7:0] PORT_BASE   = 8'hC0;
  localparam logic [7:0] PORT_OFF    = 8'h10;
  localparam logic [7:0] PORT_NIBBLE = 8'h0F;

  // classification of an item by the front end
  localparam logic [1:0] KIND_OFF  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;
  localparam logic [1:0] KIND_DIV  = 2'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] sensor_a_temp;
    logic signed [TEMP_W-1:0] sensor_b_temp;
  } reading_t;

  typedef struct packed {
    logic [3:0]               drive_level;
    logic                     fan_running;
    logic                     regulator_off;
    logic [7:0]               port_value;
    logic signed [TEMP_W-1:0] hottest_temp;
  } result_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [TEMP_W-1:0] hot;
    logic [TEMP_W-1:0]        num;
    logic [TEMP_W-1:0]        den;
  } item_t;

endpackage

FILE: hw/rtl/fthd_front.sv
// ----------------------------------------------------------------------------
// fthd_front
// Configuration registers, fan state and classification of each reading
// pair into off, zero, full or divide work for the back end.
// ----------------------------------------------------------------------------
module fthd_front
  import fthd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  reading_t             reading,
  output item_t                item
);

  logic signed [TEMP_W-1:0] low_limit;
  logic signed [TEMP_W-1:0] high_limit;
  logic [HYST_W-1:0]        hyst_band;
  logic                     fan_is_on;

  logic signed [TEMP_W-1:0] hot;
  logic signed [WIDE_W-1:0] hot_x;
  logic signed [WIDE_W-1:0] low_x;
  logic signed [WIDE_W-1:0] high_x;
  logic signed [WIDE_W-1:0] stop;
  logic signed [WIDE_W-1:0] diff;
  logic signed [WIDE_W-1:0] span;
  logic                     off;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RESET;
      high_limit <= HIGH_LIMIT_RESET;
      hyst_band  <= HYST_BAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:  low_limit  <= $signed(cfg_data[TEMP_W-1:0]);
        REG_HIGH_LIMIT: high_limit <= $signed(cfg_data[TEMP_W-1:0]);
        REG_HYST_BAND:  hyst_band  <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_is_on <= 1'b0;
    end else if (accept) begin
      fan_is_on <= !off;
    end
  end

  always_comb begin
    hot    = (reading.sensor_b_temp > reading.sensor_a_temp) ?
             reading.sensor_b_temp : reading.sensor_a_temp;
    hot_x  = {{2{hot[TEMP_W-1]}}, hot};
    low_x  = {{2{low_limit[TEMP_W-1]}}, low_limit};
    high_x = {{2{high_limit[TEMP_W-1]}}, high_limit};
    stop   = low_x - (fan_is_on ? $signed({{(WIDE_W-HYST_W){1'b0}}, hyst_band})
                                : $signed({WIDE_W{1'b0}}));
    diff   = hot_x - low_x;
    span   = high_x - low_x;
    off    = hot[TEMP_W-1] || (hot_x < stop);

    item.hot = hot;
    item.num = diff[TEMP_W-1:0];
    item.den = span[TEMP_W-1:0];
    if (off) begin
      item.kind = KIND_OFF;
    end else if (hot_x < low_x) begin
      item.kind = KIND_ZERO;
    end else if (span <= $signed({WIDE_W{1'b0}}) || diff >= span) begin
      item.kind = KIND_FULL;
    end else begin
      item.kind = KIND_DIV;
    end
  end

endmodule

FILE: hw/rtl/fthd_queue.sv
// ----------------------------------------------------------------------------
// fthd_queue
// Short queue of classified work items between front and back end.
// ----------------------------------------------------------------------------
module fthd_queue
  import fthd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/fthd_back.sv
// ----------------------------------------------------------------------------
// fthd_back
// Iterative restoring divider for the drive level, one quotient bit per
// cycle, and the result register.
// ----------------------------------------------------------------------------
module fthd_back
  import fthd_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   q_item,
  input  logic    q_empty,
  output logic    q_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  localparam int CNT_W = $clog2(LEVEL_BITS + 1);

  logic                     busy;
  logic [CNT_W-1:0]         steps;
  logic [1:0]               kind;
  logic signed [TEMP_W-1:0] hot;
  logic [TEMP_W-1:0]        den;
  logic [TEMP_W-1:0]        rem;
  logic [LEVEL_BITS-1:0]    quot;
  logic                     out_valid;

  logic [TEMP_W:0]          rem2;
  logic                     fits;
  logic                     done;
  logic                     out_free;
  logic [LEVEL_BITS-1:0]    level;
  logic [3:0]               level4;
  logic                     is_off;

  assign rem2     = {rem, 1'b0};
  assign fits     = (rem2 >= {1'b0, den});
  assign done     = busy && (steps == '0);
  assign out_free = !out_valid || pop;
  assign q_pop    = !busy && !q_empty;
  assign empty    = !out_valid;

  always_comb begin
    case (kind)
      KIND_FULL: level = '1;
      KIND_DIV:  level = quot;
      default:   level = '0;
    endcase
    level4 = 4'(level);
    is_off = (kind == KIND_OFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (q_pop) begin
      busy  <= 1'b1;
      steps <= (q_item.kind == KIND_DIV) ? CNT_W'(LEVEL_BITS) : '0;
    end else if (done) begin
      if (out_free) begin
        busy <= 1'b0;
      end
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind <= q_item.kind;
      hot  <= q_item.hot;
      den  <= q_item.den;
      rem  <= q_item.num;
      quot <= '0;
    end else if (busy && !done) begin
      rem  <= fits ? TEMP_W'(rem2 - {1'b0, den}) : rem2[TEMP_W-1:0];
      quot <= {quot[LEVEL_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      result.drive_level   <= level4;
      result.fan_running   <= !is_off;
      result.regulator_off <= is_off;
      result.port_value    <= is_off ? (PORT_BASE | PORT_OFF)
                                     : (PORT_BASE | (~{4'b0, level4} & PORT_NIBBLE));
      result.hottest_temp  <= hot;
    end
  end

endmodule

FILE: hw/rtl/fan_thermostat_hysteresis_drive_unit.sv
// ----------------------------------------------------------------------------
// fan_thermostat_hysteresis_drive_unit
// Thermostat with hysteresis and proportional fan drive level.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: a reading pair transfers when push is high and
//   full is low. Result side is a queue: the oldest result sits on result
//   while empty is low and transfers when pop is high.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 low
//   limit, 1 high limit, 2 hysteresis band); write only while idle.
//   The front end decides fan on/off and classifies each item in its
//   transfer cycle, so fan state never waits on the divider.
//   Path: an accepted item is written to the queue, loaded into the back
//   end's item registers, run through the divider when the level is
//   divided, and then registered on the result ports.
//   The back end takes a new item from the queue only after passing the
//   last one on; the restoring divider yields one quotient bit per cycle.
//   A two-entry queue separates front and back end; a stalled receiver fills
//   the result register, the back end, then the queue, and raises full.
//   Reset: limits 720 and 1040, band 48, fan off, all queues empty.
// ----------------------------------------------------------------------------
module fan_thermostat_hysteresis_drive_unit
  import fthd_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  reading_t             reading,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result
);

  item_t front_item;
  item_t q_item;
  logic  accept;
  logic  q_empty;
  logic  q_pop;

  assign accept = push && !full;

  fthd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .reading   (reading),
    .item      (front_item)
  );

  fthd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  fthd_back #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
